// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W = 32;
  localparam int PRIO_W = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP = 1'b1;

  typedef struct packed {
    logic signed [ID_W-1:0] id;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none

module spq_cell (
  input  logic            clk,
  input  spq_pkg::ctrl_t  ctrl,
  input  spq_pkg::entry_t new_entry,
  input  spq_pkg::entry_t left_entry,
  input  spq_pkg::entry_t right_entry,
  input  logic            head,
  input  logic            occupied,
  input  logic            left_hit,
  output logic            hit,
  output spq_pkg::entry_t entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;
  logic            beats;

  // When occupied, the head slot is taken only by a strictly higher priority; later slots yield on ties.
  assign beats = head ? (new_entry.prio > entry_r.prio) : (new_entry.prio >= entry_r.prio);
  assign hit = !occupied || beats;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push) begin
      if (left_hit) begin
        entry_nxt = left_entry;
      end else if (hit) begin
        entry_nxt = new_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue holding up to spq_pkg::DEPTH entries in a row of compare-and-shift
// cells. A transaction is taken on every cycle in which start is high; busy is always low,
// so a new push or pop may follow in the very next cycle. Every cell compares and shifts in
// parallel with its neighbors, and the result of each transaction is registered and appears
// on the out_ ports in the cycle after acceptance for exactly one cycle, marked by out_valid.
// The receiver cannot stall the block and must take every result.
`default_nettype none

module sorted_priority_queue_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic signed [spq_pkg::ID_W-1:0]   in_entry_id,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  output logic                              out_valid,
  output logic signed [spq_pkg::ID_W-1:0]   out_front_id,
  output logic                              out_was_empty,
  output logic                              out_dropped
);

  logic [spq_pkg::CNT_W-1:0] count_r;
  logic [spq_pkg::CNT_W-1:0] count_nxt;
  logic                      valid_r;
  logic signed [spq_pkg::ID_W-1:0] front_id_r;
  logic                      was_empty_r;
  logic                      dropped_r;

  logic                      accept;
  logic                      is_empty;
  logic                      is_full;
  spq_pkg::ctrl_t            ctrl;
  spq_pkg::entry_t           new_entry;
  spq_pkg::entry_t           cell_q [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0] hit_v;

  assign busy = 1'b0;
  assign accept = start && !busy;
  assign is_empty = (count_r == '0);
  assign is_full = (count_r == spq_pkg::CNT_W'(spq_pkg::DEPTH));

  assign ctrl.push = accept && (in_cmd == spq_pkg::CMD_PUSH) && !is_full;
  assign ctrl.pop = accept && (in_cmd == spq_pkg::CMD_POP) && !is_empty;
  assign new_entry.id = in_entry_id;
  assign new_entry.prio = in_priority_req;

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_h;
    logic            occ;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_h = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_h = hit_v[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    assign occ = (spq_pkg::CNT_W'(i) < count_r);

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .head        (i == 0),
      .occupied    (occ),
      .left_hit    (left_h),
      .hit         (hit_v[i]),
      .entry       (cell_q[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    front_id_r <= ctrl.pop ? cell_q[0].id : '0;
    was_empty_r <= (in_cmd == spq_pkg::CMD_POP) && is_empty;
    dropped_r <= (in_cmd == spq_pkg::CMD_PUSH) && is_full;
  end

  assign out_valid = valid_r;
  assign out_front_id = front_id_r;
  assign out_was_empty = was_empty_r;
  assign out_dropped = dropped_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    else $error("entry count exceeds depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_was_empty && out_dropped))
    else $error("empty and dropped flags both set");

  a_empty_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_empty) |-> (out_front_id == '0))
    else $error("empty pop reported a nonzero id");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.push || ctrl.pop) |=> (count_r != $past(count_r)))
    else $error("entry count did not change on push or pop");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 400;

  typedef struct {
    logic signed [spq_pkg::ID_W-1:0] front_id;
    logic                            was_empty;
    logic                            dropped;
  } pq_result_t;

  typedef struct {
    logic                              cmd;
    logic signed [spq_pkg::ID_W-1:0]   id;
    logic signed [spq_pkg::PRIO_W-1:0] prio;
    bit                                typed;
    pq_result_t                        known;
  } pq_stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = spq_pkg::CMD_PUSH;
  logic signed [spq_pkg::ID_W-1:0] in_entry_id = '0;
  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req = '0;
  logic out_valid;
  logic signed [spq_pkg::ID_W-1:0] out_front_id;
  logic out_was_empty;
  logic out_dropped;

  logic signed [spq_pkg::ID_W-1:0] shadow_ids[spq_pkg::DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] shadow_prios[spq_pkg::DEPTH];
  int shadow_fill = 0;

  pq_result_t awaiting_results[$];
  pq_stim_t directed_rows[$];
  int error_count = 0;
  int sender_idle_pct = 0;
  int quiet_cycles = 0;

  sorted_priority_queue_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_entry_id    (in_entry_id),
    .in_priority_req(in_priority_req),
    .out_valid      (out_valid),
    .out_front_id   (out_front_id),
    .out_was_empty  (out_was_empty),
    .out_dropped    (out_dropped)
  );

  always #5 clk = ~clk;

  function automatic pq_result_t pq_result(
    input logic signed [spq_pkg::ID_W-1:0] front_id,
    input logic was_empty, input logic dropped);
    pq_result_t r;
    r.front_id = front_id;
    r.was_empty = was_empty;
    r.dropped = dropped;
    return r;
  endfunction

  function automatic pq_stim_t pq_row(
    input logic cmd, input logic signed [spq_pkg::ID_W-1:0] id,
    input logic signed [spq_pkg::PRIO_W-1:0] prio, input bit typed,
    input pq_result_t known);
    pq_stim_t s;
    s.cmd = cmd;
    s.id = id;
    s.prio = prio;
    s.typed = typed;
    s.known = known;
    return s;
  endfunction

  function automatic pq_result_t apply_to_shadow_queue(
    input logic cmd,
    input logic signed [spq_pkg::ID_W-1:0] id,
    input logic signed [spq_pkg::PRIO_W-1:0] prio);
    pq_result_t res;
    int pos;
    res = pq_result('0, 1'b0, 1'b0);
    if (cmd == spq_pkg::CMD_POP) begin
      if (shadow_fill == 0) begin
        res.was_empty = 1'b1;
      end else begin
        res.front_id = shadow_ids[0];
        for (int i = 0; i + 1 < shadow_fill; i++) begin
          shadow_ids[i] = shadow_ids[i+1];
          shadow_prios[i] = shadow_prios[i+1];
        end
        shadow_fill--;
      end
    end else if (shadow_fill >= spq_pkg::DEPTH) begin
      res.dropped = 1'b1;
    end else begin
      if (shadow_fill == 0 || prio > shadow_prios[0]) begin
        pos = 0;
      end else begin
        pos = 1;
        while (pos < shadow_fill && prio < shadow_prios[pos]) pos++;
      end
      for (int i = shadow_fill; i > pos; i--) begin
        shadow_ids[i] = shadow_ids[i-1];
        shadow_prios[i] = shadow_prios[i-1];
      end
      shadow_ids[pos] = id;
      shadow_prios[pos] = prio;
      shadow_fill++;
    end
    return res;
  endfunction

  function automatic logic signed [spq_pkg::PRIO_W-1:0] random_priority();
    case ($urandom_range(3))
      0: return $urandom_range(4) - 2;
      1, 2: return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic pq_stim_t random_row(input int push_pct);
    logic cmd;
    cmd = ($urandom_range(99) < push_pct) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_POP;
    return pq_row(cmd, $urandom, random_priority(), 1'b0, pq_result('0, 1'b0, 1'b0));
  endfunction

  task automatic send_transaction(input pq_stim_t s);
    pq_result_t predicted;
    start <= 1'b1;
    in_cmd <= s.cmd;
    in_entry_id <= s.id;
    in_priority_req <= s.prio;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_to_shadow_queue(s.cmd, s.id, s.prio);
    awaiting_results.push_back(s.typed ? s.known : predicted);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (awaiting_results.size() != 0);
  endtask

  always @(posedge clk) begin
    pq_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (awaiting_results.size() == 0) begin
        $error("result transaction with no expectation pending: front_id=%0d", out_front_id);
        error_count++;
      end else begin
        want = awaiting_results.pop_front();
        if (out_front_id !== want.front_id) begin
          $error("front_id expected %0d actual %0d", want.front_id, out_front_id);
          error_count++;
        end
        if (out_was_empty !== want.was_empty) begin
          $error("was_empty expected %0b actual %0b", want.was_empty, out_was_empty);
          error_count++;
        end
        if (out_dropped !== want.dropped) begin
          $error("dropped expected %0b actual %0b", want.dropped, out_dropped);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pq_result_t push_ok;
    int push_pct;
    push_ok = pq_result('0, 1'b0, 1'b0);

    directed_rows.push_back(pq_row(spq_pkg::CMD_POP, 32'sh1234_5678, 32'sh7FFF_FFFF, 1'b1,
                                   pq_result('0, 1'b1, 1'b0)));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1,
                                   push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1,
                                   push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 11, 32'sh7FFF_FFFF, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 12, 32'sh7FFF_FFFF, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, -1, 0, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 0, -1, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 13, 0, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 14, 5, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 15, -5, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 16, 100, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 17, 32'sh8000_0001, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 18, 32'sh7FFF_FFFE, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 19, 0, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 20, 1, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 21, -2, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 22, 3, 1'b0, push_ok));
    directed_rows.push_back(pq_row(spq_pkg::CMD_PUSH, 23, 32'sh7FFF_FFFF, 1'b1,
                                   pq_result('0, 1'b0, 1'b1)));
    repeat (6) directed_rows.push_back(pq_row(spq_pkg::CMD_POP, -1, -1, 1'b0, push_ok));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 26;
    foreach (directed_rows[i]) send_transaction(directed_rows[i]);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 67 : 0;
      push_pct = 50;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 32 == 0) begin
          case ($urandom_range(2))
            0: push_pct = 15;
            1: push_pct = 50;
            default: push_pct = 85;
          endcase
        end
        send_transaction(random_row(push_pct));
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
bench/testbench.sv
